FILE: hdl/mrc_pkg.sv
// Package: item types, codes, register indexes and reset values for the report coalescer.
package mrc_pkg;

  localparam int GAP_BITS_DEFAULT = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BATCH_LIMIT       = 2'd0,
    REG_WINDOW_MS         = 2'd1,
    REG_FAST_GAP_MS       = 2'd2,
    REG_FAST_COUNT_NEEDED = 2'd3
  } reg_index_t;

  localparam logic [3:0] BATCH_LIMIT_RESET       = 4'd7;
  localparam logic [7:0] WINDOW_MS_RESET         = 8'd11;
  localparam logic [7:0] FAST_GAP_MS_RESET       = 8'd6;
  localparam logic [3:0] FAST_COUNT_NEEDED_RESET = 4'd5;

  localparam logic [3:0] RUN_MAX    = 4'hF;
  localparam logic [3:0] FILL_MAX   = 4'hF;
  localparam logic [7:0] WINDOW_MAX = 8'hFF;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PASS         = 2'd0,
    KIND_REPORT_FLUSH = 2'd1,
    KIND_WINDOW_FLUSH = 2'd2,
    KIND_REJECT       = 2'd3
  } kind_t;

  typedef struct packed {
    op_t               op;
    logic              link_up;
    logic [7:0]        button_bits;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0]  wheel_step;
    logic signed [7:0]  pan_step;
  } report_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        out_buttons;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [7:0]  out_wheel;
    logic signed [7:0]  out_pan;
  } result_item_t;

  typedef struct packed {
    logic [3:0] batch_limit;
    logic [7:0] window_ms;
    logic [7:0] fast_gap_ms;
    logic [3:0] fast_count_needed;
  } cfg_t;

endpackage

FILE: hdl/mrc_channels.sv
// Interfaces: valid/ready channels for report items and result items.
interface mrc_report_if import mrc_pkg::*; ;
  logic         valid;
  logic         ready;
  report_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrc_result_if import mrc_pkg::*; ;
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/mrc_cfg_regs.sv
// Configuration register file with plain write port.
module mrc_cfg_regs import mrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_limit       <= BATCH_LIMIT_RESET;
      cfg.window_ms         <= WINDOW_MS_RESET;
      cfg.fast_gap_ms       <= FAST_GAP_MS_RESET;
      cfg.fast_count_needed <= FAST_COUNT_NEEDED_RESET;
    end else if (cfg_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_BATCH_LIMIT:       cfg.batch_limit       <= cfg_data[3:0];
        REG_WINDOW_MS:         cfg.window_ms         <= cfg_data[7:0];
        REG_FAST_GAP_MS:       cfg.fast_gap_ms       <= cfg_data[7:0];
        REG_FAST_COUNT_NEEDED: cfg.fast_count_needed <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/mrc_in_stage.sv
// Input register: holds one accepted item until the core consumes it.
module mrc_in_stage import mrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mrc_report_if.sink   report,
  input  logic         out_free,
  output logic         held_valid,
  output report_item_t held_item
);

  logic advance;

  assign advance      = held_valid && out_free;
  assign report.ready = !held_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (report.ready) begin
      held_valid <= report.valid;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report.valid && report.ready) begin
      held_item <= report.data;
    end
  end

endmodule

FILE: hdl/mrc_core.sv
// Coalescer state and single-pass next-state/result logic.
module mrc_core import mrc_pkg::*; #(
  parameter int GAP_BITS = GAP_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         step,
  input  report_item_t item,
  output logic         res_valid,
  output result_item_t res
);

  localparam int CMP_W = (GAP_BITS > 8) ? GAP_BITS : 8;
  localparam logic [GAP_BITS-1:0] GAP_MAX = {GAP_BITS{1'b1}};

  logic                fast_mode, fast_mode_next;
  logic [3:0]          fast_run, fast_run_next;
  logic                seen_report, seen_report_next;
  logic [GAP_BITS-1:0] gap_ms, gap_ms_next;
  logic                timer_on, timer_on_next;
  logic [7:0]          window_count, window_count_next;
  logic [3:0]          batch_fill, batch_fill_next;
  logic [15:0]         sum_x, sum_x_next;
  logic [15:0]         sum_y, sum_y_next;
  logic [7:0]          sum_wheel, sum_wheel_next;
  logic [7:0]          sum_pan, sum_pan_next;
  logic [7:0]          held_buttons, held_buttons_next;

  logic [CMP_W-1:0] gap_ext, fast_gap_ext;

  assign gap_ext      = CMP_W'(gap_ms);
  assign fast_gap_ext = CMP_W'(cfg.fast_gap_ms);

  always_comb begin
    logic [7:0] wc_inc;
    logic [3:0] run_inc;
    logic       fm;
    logic       batch_full;

    fast_mode_next    = fast_mode;
    fast_run_next     = fast_run;
    seen_report_next  = seen_report;
    gap_ms_next       = gap_ms;
    timer_on_next     = timer_on;
    window_count_next = window_count;
    batch_fill_next   = batch_fill;
    sum_x_next        = sum_x;
    sum_y_next        = sum_y;
    sum_wheel_next    = sum_wheel;
    sum_pan_next      = sum_pan;
    held_buttons_next = held_buttons;
    res_valid         = 1'b0;
    res               = '0;
    wc_inc            = (window_count != WINDOW_MAX) ? window_count + 8'd1 : window_count;
    run_inc           = (fast_run != RUN_MAX) ? fast_run + 4'd1 : fast_run;
    fm                = fast_mode;
    batch_full        = (batch_fill >= cfg.batch_limit);

    if (item.op == OP_TICK) begin
      if (gap_ms != GAP_MAX) gap_ms_next = gap_ms + 1'b1;
      if (timer_on) begin
        window_count_next = wc_inc;
        if (wc_inc >= cfg.window_ms) begin
          window_count_next = '0;
          if ((sum_x | sum_y) != 16'd0 || (sum_wheel | sum_pan | held_buttons) != 8'd0) begin
            res_valid       = 1'b1;
            res.kind        = KIND_WINDOW_FLUSH;
            res.out_buttons = held_buttons;
            res.out_x       = sum_x;
            res.out_y       = sum_y;
            res.out_wheel   = sum_wheel;
            res.out_pan     = sum_pan;
            sum_x_next      = '0;
            sum_y_next      = '0;
            sum_wheel_next  = '0;
            sum_pan_next    = '0;
          end
        end
      end
    end else if (!item.link_up) begin
      // rejected: no state change, zero payload
      res_valid = 1'b1;
      res.kind  = KIND_REJECT;
    end else begin
      if (!fast_mode) begin
        if (seen_report) begin
          if (gap_ext < fast_gap_ext) begin
            fast_run_next = run_inc;
            if (run_inc >= cfg.fast_count_needed) fm = 1'b1;
          end else begin
            fast_run_next = '0;
          end
        end
        seen_report_next = 1'b1;
        gap_ms_next      = '0;
      end
      fast_mode_next = fm;

      if (!fm) begin
        res_valid       = 1'b1;
        res.kind        = KIND_PASS;
        res.out_buttons = item.button_bits;
        res.out_x       = item.move_x;
        res.out_y       = item.move_y;
        res.out_wheel   = item.wheel_step;
        res.out_pan     = item.pan_step;
      end else begin
        if (!timer_on) begin
          timer_on_next     = 1'b1;
          window_count_next = '0;
        end
        if (held_buttons != item.button_bits || batch_full) begin
          // flush: this report's motion is dropped
          res_valid         = 1'b1;
          res.kind          = KIND_REPORT_FLUSH;
          res.out_buttons   = item.button_bits;
          res.out_x         = sum_x;
          res.out_y         = sum_y;
          res.out_wheel     = sum_wheel;
          res.out_pan       = sum_pan;
          held_buttons_next = item.button_bits;
          if (batch_full) begin
            sum_x_next      = '0;
            sum_y_next      = '0;
            sum_wheel_next  = '0;
            sum_pan_next    = '0;
            batch_fill_next = '0;
          end
          window_count_next = '0;
        end else begin
          held_buttons_next = item.button_bits;
          sum_x_next        = sum_x + $unsigned(item.move_x);
          sum_y_next        = sum_y + $unsigned(item.move_y);
          sum_wheel_next    = sum_wheel + $unsigned(item.wheel_step);
          sum_pan_next      = sum_pan + $unsigned(item.pan_step);
          if (batch_fill != FILL_MAX) batch_fill_next = batch_fill + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_mode    <= 1'b0;
      fast_run     <= '0;
      seen_report  <= 1'b0;
      gap_ms       <= '0;
      timer_on     <= 1'b0;
      window_count <= '0;
      batch_fill   <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_wheel    <= '0;
      sum_pan      <= '0;
      held_buttons <= '0;
    end else if (step) begin
      fast_mode    <= fast_mode_next;
      fast_run     <= fast_run_next;
      seen_report  <= seen_report_next;
      gap_ms       <= gap_ms_next;
      timer_on     <= timer_on_next;
      window_count <= window_count_next;
      batch_fill   <= batch_fill_next;
      sum_x        <= sum_x_next;
      sum_y        <= sum_y_next;
      sum_wheel    <= sum_wheel_next;
      sum_pan      <= sum_pan_next;
      held_buttons <= held_buttons_next;
    end
  end

endmodule

FILE: hdl/mrc_out_stage.sv
// Result register: holds one result item until the sink takes it.
module mrc_out_stage import mrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_item_t res,
  output logic         out_free,
  mrc_result_if.source result
);

  assign out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.data <= res;
    end
  end

endmodule

FILE: hdl/mouse_report_coalescer_unit.sv
// Top level of the mouse report coalescer.
//
// Accepts one item per clock while ready is high: a mouse report or a
// one-millisecond tick. Each accepted item is held in the input register,
// is evaluated in a single pass by the core, and its result (if any) lands
// in the result register. With the result side never stalling, throughput
// is one item every cycle; a stalled result register holds the input
// register, and ready drops only when both are full. Reports pass through
// until enough consecutive short gaps have been seen, then motion is summed
// and emitted on a button change, a full batch, or the window timer.
// Configuration writes take effect at the edge they are issued and must
// only be made while no item is in flight.
module mouse_report_coalescer_unit import mrc_pkg::*; #(
  parameter int GAP_BITS = GAP_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  mrc_report_if.sink             report,
  mrc_result_if.source           result,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t         cfg;
  logic         out_free;
  logic         held_valid;
  report_item_t held_item;
  logic         step;
  logic         res_valid;
  result_item_t res;

  // core state advances only when the held item moves on
  assign step = held_valid && out_free;

  mrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .report     (report),
    .out_free   (out_free),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mrc_core #(
    .GAP_BITS (GAP_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // only items that produce a result load the result register
  mrc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .res      (res),
    .out_free (out_free),
    .result   (result)
  );

endmodule
